// ----- src/rpnp_pkg.sv -----
// ----------------------------------------------------------------------------
// rpnp_pkg
// Shared types and constants for the radix-prefixed number parser.
// ----------------------------------------------------------------------------
package rpnp_pkg;

  localparam int CHAR_BITS = 8;
  localparam int OUT_BITS  = 32;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_EMPTY     = 3'd1,
    ST_NO_RADIX  = 3'd2,
    ST_BAD_DIGIT = 3'd3,
    ST_RANGE     = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    RADIX_2  = 2'd0,
    RADIX_8  = 2'd1,
    RADIX_10 = 2'd2,
    RADIX_16 = 2'd3
  } radix_t;

  // Classification of one character.
  typedef struct packed {
    logic       is_term;
    logic       is_prefix;
    radix_t     prefix_radix;
    logic       is_dec;
    logic       is_digit;
    logic [3:0] digit;
  } char_class_t;

  typedef struct packed {
    logic [OUT_BITS-1:0] value;
    status_t             status;
  } result_t;

endpackage

// ----- src/rpnp_ifs.sv -----
// ----------------------------------------------------------------------------
// rpnp_ifs
// Valid/ready channels of the parser: character input and result output.
// ----------------------------------------------------------------------------
interface rpnp_char_if import rpnp_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CHAR_BITS-1:0] char_code;

  modport source (output valid, output char_code, input ready);
  modport sink   (input valid, input char_code, output ready);
endinterface

interface rpnp_result_if import rpnp_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [OUT_BITS-1:0] value;
  status_t             status;

  modport source (output valid, output value, output status, input ready);
  modport sink   (input valid, input value, input status, output ready);
endinterface

// ----- src/rpnp_decode.sv -----
// ----------------------------------------------------------------------------
// rpnp_decode
// Classifies one character: terminator, radix prefix, decimal or hex digit.
// ----------------------------------------------------------------------------
module rpnp_decode import rpnp_pkg::*; (
  input  logic [CHAR_BITS-1:0] char_code,
  output char_class_t          cls
);

  localparam logic [CHAR_BITS-1:0] CH_NUL = 8'h00;
  localparam logic [CHAR_BITS-1:0] CH_0   = 8'h30;
  localparam logic [CHAR_BITS-1:0] CH_9   = 8'h39;
  localparam logic [CHAR_BITS-1:0] CH_UA  = 8'h41;
  localparam logic [CHAR_BITS-1:0] CH_UB  = 8'h42;
  localparam logic [CHAR_BITS-1:0] CH_UF  = 8'h46;
  localparam logic [CHAR_BITS-1:0] CH_UH  = 8'h48;
  localparam logic [CHAR_BITS-1:0] CH_UQ  = 8'h51;
  localparam logic [CHAR_BITS-1:0] CH_LA  = 8'h61;
  localparam logic [CHAR_BITS-1:0] CH_LB  = 8'h62;
  localparam logic [CHAR_BITS-1:0] CH_LF  = 8'h66;
  localparam logic [CHAR_BITS-1:0] CH_LH  = 8'h68;
  localparam logic [CHAR_BITS-1:0] CH_LQ  = 8'h71;
  localparam logic [CHAR_BITS-1:0] TEN    = 8'd10;

  logic is_lower_hex;
  logic is_upper_hex;

  always_comb begin
    cls              = '0;
    cls.is_term      = (char_code == CH_NUL);
    cls.is_dec       = (char_code >= CH_0) && (char_code <= CH_9);
    is_lower_hex     = (char_code >= CH_LA) && (char_code <= CH_LF);
    is_upper_hex     = (char_code >= CH_UA) && (char_code <= CH_UF);
    cls.is_digit     = cls.is_dec || is_lower_hex || is_upper_hex;
    cls.prefix_radix = RADIX_2;

    if (cls.is_dec) begin
      cls.digit = 4'(char_code - CH_0);
    end else if (is_lower_hex) begin
      cls.digit = 4'(char_code - CH_LA + TEN);
    end else if (is_upper_hex) begin
      cls.digit = 4'(char_code - CH_UA + TEN);
    end else begin
      cls.digit = 4'd0;
    end

    if (char_code == CH_LB || char_code == CH_UB) begin
      cls.is_prefix    = 1'b1;
      cls.prefix_radix = RADIX_2;
    end else if (char_code == CH_LQ || char_code == CH_UQ) begin
      cls.is_prefix    = 1'b1;
      cls.prefix_radix = RADIX_8;
    end else if (char_code == CH_LH || char_code == CH_UH) begin
      cls.is_prefix    = 1'b1;
      cls.prefix_radix = RADIX_16;
    end else begin
      cls.is_prefix    = 1'b0;
    end
  end

endmodule

// ----- src/rpnp_accum.sv -----
// ----------------------------------------------------------------------------
// rpnp_accum
// Parser state: radix selection, shift-add accumulator and sticky error.
// ----------------------------------------------------------------------------
module rpnp_accum import rpnp_pkg::*; #(
  parameter int VALUE_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        step,
  input  char_class_t cls,
  output result_t     res
);

  localparam int WIDE_BITS = VALUE_BITS + 4;

  logic                  at_start;
  radix_t                radix_sel;
  logic [VALUE_BITS-1:0] accumulator;
  status_t               error_code;

  logic [WIDE_BITS-1:0]  wide_acc;
  logic [WIDE_BITS-1:0]  scaled;
  logic [WIDE_BITS-1:0]  sum;
  logic                  digit_fits;
  logic                  overflow;

  // acc * radix is done with shifts; four guard bits catch any overflow
  // from both the multiply and the digit add.
  always_comb begin
    wide_acc = {4'b0, accumulator};
    case (radix_sel)
      RADIX_2: begin
        scaled     = wide_acc << 1;
        digit_fits = (cls.digit[3:1] == 3'd0);
      end
      RADIX_8: begin
        scaled     = wide_acc << 3;
        digit_fits = !cls.digit[3];
      end
      RADIX_10: begin
        scaled     = (wide_acc << 3) + (wide_acc << 1);
        digit_fits = (cls.digit <= 4'd9);
      end
      RADIX_16: begin
        scaled     = wide_acc << 4;
        digit_fits = 1'b1;
      end
      default: begin
        scaled     = '0;
        digit_fits = 1'b0;
      end
    endcase
    sum      = scaled + {{VALUE_BITS{1'b0}}, cls.digit};
    overflow = |sum[WIDE_BITS-1:VALUE_BITS];
  end

  always_comb begin
    res.status = at_start ? ST_EMPTY : error_code;
    res.value  = (res.status == ST_OK) ? OUT_BITS'(accumulator) : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      at_start    <= 1'b1;
      radix_sel   <= RADIX_2;
      accumulator <= '0;
      error_code  <= ST_OK;
    end else if (step) begin
      if (cls.is_term) begin
        at_start    <= 1'b1;
        radix_sel   <= RADIX_2;
        accumulator <= '0;
        error_code  <= ST_OK;
      end else if (at_start) begin
        at_start <= 1'b0;
        if (cls.is_prefix) begin
          radix_sel <= cls.prefix_radix;
        end else if (cls.is_dec) begin
          // The accumulator is zero here, so the first digit just loads.
          radix_sel   <= RADIX_10;
          accumulator <= VALUE_BITS'(cls.digit);
        end else begin
          error_code <= ST_NO_RADIX;
        end
      end else if (error_code == ST_OK) begin
        if (!cls.is_digit || !digit_fits) begin
          error_code <= ST_BAD_DIGIT;
        end else if (overflow) begin
          error_code <= ST_RANGE;
        end else begin
          accumulator <= sum[VALUE_BITS-1:0];
        end
      end
    end
  end

  a_term_clears: assert property (@(posedge clk) disable iff (rst)
    step && cls.is_term |=> at_start && error_code == ST_OK && accumulator == '0)
    else $error("state not cleared after terminator");

  a_error_sticks: assert property (@(posedge clk) disable iff (rst)
    step && !cls.is_term && !at_start && error_code != ST_OK
    |=> error_code == $past(error_code) && accumulator == $past(accumulator))
    else $error("sticky error or accumulator changed after error");

  a_first_char: assert property (@(posedge clk) disable iff (rst)
    step && !cls.is_term && at_start |=> !at_start)
    else $error("first character did not leave start state");

  a_no_empty_code: assert property (@(posedge clk) disable iff (rst)
    error_code != ST_EMPTY)
    else $error("empty-string status held as sticky error");

endmodule

// ----- src/radix_prefixed_number_parser_core.sv -----
// ----------------------------------------------------------------------------
// radix_prefixed_number_parser_core
// Parses a zero-terminated ASCII string into an unsigned value with status.
// ----------------------------------------------------------------------------
// The block takes one character per cycle on char_in while no zero byte waits
// for a held result, and gives one result transaction on result_out for each
// zero byte. A leading b/B, q/Q or h/H selects binary, octal or hex; a leading
// decimal digit selects decimal. Each character goes through an input register,
// is decoded and folded into the shift-add accumulator, and a terminator's
// result is loaded into the output register, from which it is offered. The
// output register decouples the two sides: a held result stalls only a later
// zero byte, while ordinary characters keep flowing. Status: 0 ok, 1 empty
// string, 2 undefined radix, 3 digit not allowed, 4 range over; value is zero
// unless status is ok.
module radix_prefixed_number_parser_core import rpnp_pkg::*; #(
  parameter int VALUE_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  rpnp_char_if.sink            char_in,
  rpnp_result_if.source        result_out
);

  logic                 s1_valid;
  logic [CHAR_BITS-1:0] s1_char;
  logic                 s1_adv;
  char_class_t          s1_cls;
  result_t              step_res;

  logic                 out_valid;
  result_t              out_res;

  rpnp_decode u_decode (
    .char_code (s1_char),
    .cls       (s1_cls)
  );

  rpnp_accum #(
    .VALUE_BITS (VALUE_BITS)
  ) u_accum (
    .clk  (clk),
    .rst  (rst),
    .step (s1_adv),
    .cls  (s1_cls),
    .res  (step_res)
  );

  // Only a terminator needs the output register to be free.
  assign s1_adv        = s1_valid && (!s1_cls.is_term || !out_valid || result_out.ready);
  assign char_in.ready = !s1_valid || s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (char_in.ready) begin
        s1_valid <= char_in.valid;
      end
      if (s1_adv && s1_cls.is_term) begin
        out_valid <= 1'b1;
      end else if (result_out.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (char_in.valid && char_in.ready) begin
      s1_char <= char_in.char_code;
    end
    if (s1_adv && s1_cls.is_term) begin
      out_res <= step_res;
    end
  end

  assign result_out.valid  = out_valid;
  assign result_out.value  = out_res.value;
  assign result_out.status = out_res.status;

endmodule
